/* rtl/core/prqb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package prqb_pkg;

   // Capacity of the task store and the widths that follow from it.
   localparam int MAX_TASKS = 16;
   localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CNT_W     = $clog2(MAX_TASKS + 1);

   // Queue between the loader and the sort engine; depth is a power of two.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [7:0]  prio;
      logic [15:0] exec;
      logic [15:0] rem;
      logic [5:0]  tag;
   } task_rec_type;

   localparam int REC_W = $bits(task_rec_type);

   // One loaded request as it travels from the loader to the sort engine.
   typedef struct packed {
      task_rec_type     rec;
      logic             keep;   // store has room for this task
      logic             last;   // closes the set
      logic [CNT_W-1:0] count;  // tasks stored once this request is taken
   } load_entry_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } queue_status_type;

   typedef enum logic [2:0] {
      BK_LOAD,
      BK_RD_I,
      BK_LD_I,
      BK_CMP,
      BK_FIN,
      BK_DONE
   } back_state_type;

endpackage

`default_nettype wire

/* rtl/core/prqb_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module prqb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/core/prqb_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module prqb_front
   import prqb_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire task_rec_type     req_rec,
   input  wire logic             req_last,
   input  wire queue_status_type q_status,
   output logic                  push,
   output load_entry_type        push_entry
);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             keep;
   logic [CNT_W-1:0] count_after;

   // Tasks beyond the store's capacity are dropped, but their last flag still counts.
   always_comb begin
      keep        = (count_ff < CNT_W'(MAX_TASKS));
      count_after = keep ? (count_ff + CNT_W'(1)) : count_ff;
      req_ready   = !q_status.full;
      push        = req_valid && req_ready;

      push_entry.rec   = req_rec;
      push_entry.keep  = keep;
      push_entry.last  = req_last;
      push_entry.count = count_after;

      count_in = count_ff;
      if (push) begin
         count_in = req_last ? '0 : count_after;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/prqb_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module prqb_queue
   import prqb_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           push,
   input  wire load_entry_type push_entry,
   input  wire logic           pop,
   output load_entry_type      head,
   output queue_status_type    status
);

   load_entry_type    slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] fill_ff, fill_in;

   always_comb begin
      status.not_empty = (fill_ff != '0);
      status.full      = (fill_ff == QCNT_W'(QUEUE_DEPTH));
      head             = slot_ff[rd_ptr_ff];

      wr_ptr_in = push ? (wr_ptr_ff + QPTR_W'(1)) : wr_ptr_ff;
      rd_ptr_in = pop  ? (rd_ptr_ff + QPTR_W'(1)) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/prqb_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module prqb_back
   import prqb_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire load_entry_type   head,
   input  wire queue_status_type q_status,
   output logic                  pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output task_rec_type          rsp_rec,
   output logic                  rsp_empty,
   output logic                  rsp_last
);

   back_state_type   state_ff, state_in;
   logic [CNT_W-1:0] n_ff, n_in;
   logic [CNT_W-1:0] i_ff, i_in;
   logic [CNT_W-1:0] j_ff, j_in;
   task_rec_type     cur_ff, cur_in;
   task_rec_type     pend_ff, pend_in;
   logic             have_pend_ff, have_pend_in;
   logic             out_valid_ff, out_valid_in;
   task_rec_type     out_rec_ff, out_rec_in;
   logic             out_empty_ff, out_empty_in;
   logic             out_last_ff, out_last_in;

   logic             ram_wr_en;
   logic [IDX_W-1:0] ram_wr_addr;
   task_rec_type     ram_wr_data;
   logic [IDX_W-1:0] ram_rd_addr;
   logic [REC_W-1:0] ram_rd_bits;
   task_rec_type     ram_rd_rec;

   logic             out_free;
   logic             qual;
   logic             need_out;
   logic [CNT_W-1:0] j_next;
   logic [CNT_W-1:0] i_next;
   logic [CNT_W-1:0] load_addr;

   prqb_ram #(
      .WIDTH (REC_W),
      .DEPTH (MAX_TASKS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_bits)
   );

   assign ram_rd_rec = task_rec_type'(ram_rd_bits);

   // Position i is held in cur while every later j is read; a later task of
   // higher priority trades places with it, so cur ends as the final entry at i.
   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      cur_in       = cur_ff;
      pend_in      = pend_ff;
      have_pend_in = have_pend_ff;
      out_rec_in   = out_rec_ff;
      out_empty_in = out_empty_ff;
      out_last_in  = out_last_ff;

      out_free     = !out_valid_ff || rsp_ready;
      out_valid_in = out_valid_ff && !rsp_ready;

      pop          = 1'b0;
      ram_wr_en    = 1'b0;
      load_addr    = head.count - CNT_W'(1);
      ram_wr_addr  = load_addr[IDX_W-1:0];
      ram_wr_data  = head.rec;
      ram_rd_addr  = i_ff[IDX_W-1:0];

      qual     = (cur_ff.rem != '0);
      need_out = qual && have_pend_ff;
      j_next   = j_ff + CNT_W'(1);
      i_next   = i_ff + CNT_W'(1);

      unique case (state_ff)
         BK_LOAD: begin
            if (q_status.not_empty) begin
               pop       = 1'b1;
               ram_wr_en = head.keep;
               if (head.last) begin
                  n_in         = head.count;
                  i_in         = '0;
                  have_pend_in = 1'b0;
                  state_in     = BK_RD_I;
               end
            end
         end
         BK_RD_I: begin
            ram_rd_addr = i_ff[IDX_W-1:0];
            j_in        = i_next;
            state_in    = BK_LD_I;
         end
         BK_LD_I: begin
            cur_in      = ram_rd_rec;
            ram_rd_addr = j_ff[IDX_W-1:0];
            state_in    = (j_ff < n_ff) ? BK_CMP : BK_FIN;
         end
         BK_CMP: begin
            if (ram_rd_rec.prio > cur_ff.prio) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = j_ff[IDX_W-1:0];
               ram_wr_data = cur_ff;
               cur_in      = ram_rd_rec;
            end
            ram_rd_addr = j_next[IDX_W-1:0];
            j_in        = j_next;
            state_in    = (j_next < n_ff) ? BK_CMP : BK_FIN;
         end
         BK_FIN: begin
            // A qualifying task is held back one place so that the final one
            // can be marked as last.
            if (!need_out || out_free) begin
               if (need_out) begin
                  out_valid_in = 1'b1;
                  out_rec_in   = pend_ff;
                  out_empty_in = 1'b0;
                  out_last_in  = 1'b0;
               end
               if (qual) begin
                  pend_in      = cur_ff;
                  have_pend_in = 1'b1;
               end
               i_in     = i_next;
               state_in = (i_next < n_ff) ? BK_RD_I : BK_DONE;
            end
         end
         BK_DONE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_rec_in   = have_pend_ff ? pend_ff : '0;
               out_empty_in = !have_pend_ff;
               out_last_in  = have_pend_ff;
               state_in     = BK_LOAD;
            end
         end
         default: begin
            state_in = BK_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_pend_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         have_pend_ff <= have_pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      cur_ff       <= cur_in;
      pend_ff      <= pend_in;
      out_rec_ff   <= out_rec_in;
      out_empty_ff <= out_empty_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_rec   = out_rec_ff;
   assign rsp_empty = out_empty_ff;
   assign rsp_last  = out_last_ff;

   a_cmp_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_CMP) |-> (j_ff > i_ff) && (j_ff < n_ff))
      else $error("compare index outside the set");

   a_set_size: assert property (@(posedge clock) disable iff (reset)
      (state_ff != BK_LOAD) |-> (n_ff != '0) && (n_ff <= CNT_W'(MAX_TASKS)))
      else $error("set size out of range while sorting");

   a_empty_not_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_empty_ff) |-> !out_last_ff && (out_rec_ff == '0))
      else $error("empty result carries data or last flag");

   a_done_emits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_DONE) && out_free |=> out_valid_ff && (state_ff == BK_LOAD))
      else $error("closing result not issued");

endmodule

`default_nettype wire

/* rtl/core/priority_ready_queue_builder.sv */
`timescale 1ns / 1ps
`default_nettype none

// Priority ready queue builder.
// Requests on the req_ channel each carry one task record; the request with
// req_set_last high closes a set. Up to MAX_TASKS tasks of a set are stored in
// arrival order; further tasks of the same set are dropped, their last flag kept.
// Once a set is closed the store is exchange-sorted into descending priority
// and every task with non-zero remaining time is returned on the rsp_ channel
// in that order, the final one with rsp_run_last high. A set with no such task
// gives a single response with rsp_queue_empty high and all other fields zero.
// Loading takes one request per cycle through a four-entry queue while the
// queue is not full. The pace of the sort is set by the single read port of
// the task store; meanwhile requests of the next set are taken until the
// queue fills. With two or more qualifying tasks the first response is issued
// while the sort goes on; otherwise the only response comes at the end of the
// sort.
// A stalled rsp_ready holds the response register and, once a second result is
// due, the sort engine, which in turn lets the queue fill and lowers req_ready.
// Reset empties the queue, zeroes the task count and drops any pending
// response; the task store itself is not cleared and needs no clearing pass.

module priority_ready_queue_builder
   import prqb_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_task_priority,
   input  wire logic [15:0] req_task_exec_time,
   input  wire logic [15:0] req_task_remaining,
   input  wire logic [5:0]  req_task_tag,
   input  wire logic        req_set_last,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [5:0]       rsp_out_tag,
   output logic [7:0]       rsp_out_priority,
   output logic [15:0]      rsp_out_exec_time,
   output logic [15:0]      rsp_out_remaining,
   output logic             rsp_queue_empty,
   output logic             rsp_run_last
);

   task_rec_type     req_rec;
   task_rec_type     rsp_rec;
   queue_status_type q_status;
   load_entry_type   push_entry;
   load_entry_type   head;
   logic             push;
   logic             pop;

   // Gather the request fields into one record.
   always_comb begin
      req_rec.prio = req_task_priority;
      req_rec.exec = req_task_exec_time;
      req_rec.rem  = req_task_remaining;
      req_rec.tag  = req_task_tag;
   end

   // The loader numbers each task and decides whether it fits the store.
   prqb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_rec    (req_rec),
      .req_last   (req_set_last),
      .q_status   (q_status),
      .push       (push),
      .push_entry (push_entry)
   );

   // Short queue that lets loading run ahead while a set is being sorted.
   prqb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   // The sort engine owns the task store and the response register.
   prqb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .q_status  (q_status),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_rec   (rsp_rec),
      .rsp_empty (rsp_queue_empty),
      .rsp_last  (rsp_run_last)
   );

   assign rsp_out_tag       = rsp_rec.tag;
   assign rsp_out_priority  = rsp_rec.prio;
   assign rsp_out_exec_time = rsp_rec.exec;
   assign rsp_out_remaining = rsp_rec.rem;

endmodule

`default_nettype wire
